[hw/rtl/btx_pkg.sv]
// Shared widths, codes and control types of the binary trie max-xor core.
`timescale 1ns / 1ps
`default_nettype none
package btx_pkg;

   // Fixed widths of the request and response fields
   localparam int unsigned KEY_W  = 31;
   localparam int unsigned TYPE_W = 2;
   localparam int unsigned STAT_W = 2;

   // Request types
   localparam logic [TYPE_W-1:0] OP_INS = 2'd0;
   localparam logic [TYPE_W-1:0] OP_ERA = 2'd1;
   localparam logic [TYPE_W-1:0] OP_QRY = 2'd2;
   localparam logic [TYPE_W-1:0] OP_NOP = 2'd3;

   // Response status codes
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

   // Write enables of the node store
   typedef struct packed {
      logic lnk_we;
      logic cnt_we;
      logic root_we;
   } nm_ctl_type;

endpackage
`default_nettype wire

[hw/rtl/btx_path_cell.sv]
// One cell of the path chain: holds one node index, shifts in either direction.
`timescale 1ns / 1ps
`default_nettype none
module btx_path_cell
   import btx_pkg::*;
#(
   parameter int unsigned ID_W = 15
) (
   input  wire logic            clock,
   input  wire logic            push,
   input  wire logic            pop,
   input  wire logic [ID_W-1:0] from_left,
   input  wire logic [ID_W-1:0] from_right,
   output logic      [ID_W-1:0] val
);

   logic [ID_W-1:0] val_ff;

   // Take the left neighbor on push, the right neighbor on pop, else hold
   always_ff @(posedge clock) begin
      if (push) begin
         val_ff <= from_left;
      end else if (pop) begin
         val_ff <= from_right;
      end
   end

   assign val = val_ff;

endmodule
`default_nettype wire

[hw/rtl/btx_node_mem.sv]
// Node store: child links and counts of every trie node, root links in flops.
`timescale 1ns / 1ps
`default_nettype none
module btx_node_mem
   import btx_pkg::*;
#(
   parameter int unsigned NODE_COUNT = 32768,
   parameter int unsigned CNT_W      = 11
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire nm_ctl_type                       ctl,
   input  wire logic [$clog2(NODE_COUNT)-1:0]    lnk_ra,
   input  wire logic [$clog2(NODE_COUNT)-1:0]    cnt_ra,
   input  wire logic [$clog2(NODE_COUNT)-1:0]    lnk_wa,
   input  wire logic [2*$clog2(NODE_COUNT)-1:0]  lnk_wd,
   input  wire logic [$clog2(NODE_COUNT)-1:0]    cnt_wa,
   input  wire logic [CNT_W-1:0]                 cnt_wd,
   output logic      [2*$clog2(NODE_COUNT)-1:0]  lnk_q,
   output logic      [CNT_W-1:0]                 cnt_q
);

   localparam int unsigned IW  = $clog2(NODE_COUNT);
   localparam int unsigned LKW = 2 * IW;

   logic [LKW-1:0]   lnk_mem [NODE_COUNT];
   logic [CNT_W-1:0] cnt_mem [NODE_COUNT];
   logic [LKW-1:0]   lnk_q_ff;
   logic [CNT_W-1:0] cnt_q_ff;
   logic             rd_root_ff;
   logic [LKW-1:0]   root_lnk_ff;

   // Link memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (ctl.lnk_we) begin
         lnk_mem[lnk_wa] <= lnk_wd;
      end
      lnk_q_ff <= lnk_mem[lnk_ra];
   end

   // Count memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (ctl.cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_q_ff <= cnt_mem[cnt_ra];
   end

   // Keep the root links in flops so reset clears them
   always_ff @(posedge clock) begin
      if (reset) begin
         root_lnk_ff <= '0;
         rd_root_ff  <= 1'b0;
      end else begin
         if (ctl.root_we) begin
            root_lnk_ff <= lnk_wd;
         end
         rd_root_ff <= (lnk_ra == '0);
      end
   end

   assign lnk_q = rd_root_ff ? root_lnk_ff : lnk_q_ff;
   assign cnt_q = cnt_q_ff;

endmodule
`default_nettype wire

[hw/rtl/binary_trie_max_xor_core.sv]
// Top level: request sequencer walking the trie, with a chain of path cells.
// Each walk step of a request waits on one registered read of the node store.
// One request is worked at a time; a new one is taken while a response waits.
// Reset clears the root links, node and value totals and all control state;
// other node entries are written when a node is taken, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module binary_trie_max_xor_core
   import btx_pkg::*;
#(
   parameter int unsigned KEY_BITS   = 31,
   parameter int unsigned MAX_VALUES = 1024,
   parameter int unsigned NODE_COUNT = 32768
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [TYPE_W-1:0] req_type,
   input  wire logic [KEY_W-1:0]  req_key_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [KEY_W-1:0]  rsp_best_xor,
   output logic      [STAT_W-1:0] rsp_status
);

   localparam int unsigned IW  = $clog2(NODE_COUNT);
   localparam int unsigned LKW = 2 * IW;
   localparam int unsigned CW  = $clog2(MAX_VALUES + 1);
   localparam int unsigned LW  = $clog2(KEY_BITS);
   localparam int unsigned NW  = $clog2(KEY_BITS + 1);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_WALK = 8'b0000_0010,
      S_CHK  = 8'b0000_0100,
      S_INC  = 8'b0000_1000,
      S_NEW  = 8'b0001_0000,
      S_QLNK = 8'b0010_0000,
      S_QCNT = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [TYPE_W-1:0] op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [LW-1:0]     lvl_ff, lvl_in;
   logic [IW-1:0]     node_ff, node_in;
   logic [KEY_BITS-1:0] best_ff, best_in;
   logic [STAT_W-1:0] st_ff, st_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [LW-1:0]     fail_ff, fail_in;
   logic              miss_ff, miss_in;
   logic [LKW-1:0]    plnk_ff, plnk_in;
   logic [IW-1:0]     parent_ff, parent_in;
   logic [IW-1:0]     other_ff, other_in;
   logic [IW-1:0]     same_ff, same_in;
   logic              pend_ff, pend_in;
   logic [IW-1:0]     pend_addr_ff, pend_addr_in;
   logic [IW-1:0]     nf_ff, nf_in;
   logic [CW-1:0]     total_ff, total_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]  rsp_best_ff, rsp_best_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   nm_ctl_type        ctl;
   logic [IW-1:0]     lnk_ra, cnt_ra, lnk_wa, cnt_wa;
   logic [LKW-1:0]    lnk_wd, lnk_q;
   logic [CW-1:0]     cnt_wd, cnt_q;

   logic              push, pop;
   logic [IW-1:0]     push_val;
   logic [IW-1:0]     cell_val [KEY_BITS];

   logic [63:0]       key_ext, best_ext;
   logic              out_free, kb, take;
   logic [IW-1:0]     lo, hi, nxt, new_id, child_id;
   logic [IW:0]       need;
   logic [LW-1:0]     lvl_dn;

   // Node store
   btx_node_mem #(
      .NODE_COUNT(NODE_COUNT),
      .CNT_W     (CW)
   ) u_mem (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .lnk_ra(lnk_ra),
      .cnt_ra(cnt_ra),
      .lnk_wa(lnk_wa),
      .lnk_wd(lnk_wd),
      .cnt_wa(cnt_wa),
      .cnt_wd(cnt_wd),
      .lnk_q (lnk_q),
      .cnt_q (cnt_q)
   );

   // Path chain: nodes pushed during the walk, popped for count updates
   for (genvar gi = 0; gi < KEY_BITS; gi++) begin : g_cell
      logic [IW-1:0] left_v, right_v;
      if (gi == 0) begin : g_head
         assign left_v = push_val;
      end else begin : g_mid
         assign left_v = cell_val[gi-1];
      end
      if (gi == KEY_BITS - 1) begin : g_tail
         assign right_v = '0;
      end else begin : g_body
         assign right_v = cell_val[gi+1];
      end
      btx_path_cell #(.ID_W(IW)) u_cell (
         .clock     (clock),
         .push      (push),
         .pop       (pop),
         .from_left (left_v),
         .from_right(right_v),
         .val       (cell_val[gi])
      );
   end

   assign key_ext  = 64'(req_key_value);
   assign best_ext = 64'(best_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign kb       = key_ff[lvl_ff];
   assign lo       = lnk_q[IW-1:0];
   assign hi       = lnk_q[LKW-1:IW];
   assign nxt      = kb ? hi : lo;
   assign new_id   = nf_ff + IW'(1);
   assign child_id = new_id + IW'(1);
   assign lvl_dn   = lvl_ff - LW'(1);
   assign need     = {1'b0, nf_ff} + (IW+1)'(miss_ff) + (IW+1)'(fail_ff);
   assign take     = (other_ff != '0) && (cnt_q != '0);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      lvl_in        = lvl_ff;
      node_in       = node_ff;
      best_in       = best_ff;
      st_in         = st_ff;
      n_in          = n_ff;
      fail_in       = fail_ff;
      miss_in       = miss_ff;
      plnk_in       = plnk_ff;
      parent_in     = parent_ff;
      other_in      = other_ff;
      same_in       = same_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      nf_in         = nf_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_best_in   = rsp_best_ff;
      rsp_status_in = rsp_status_ff;
      ctl           = '0;
      lnk_ra        = node_ff;
      cnt_ra        = other_ff;
      lnk_wa        = parent_ff;
      lnk_wd        = plnk_ff;
      cnt_wa        = pend_addr_ff;
      cnt_wd        = (op_ff == OP_ERA) ? (cnt_q - CW'(1)) : (cnt_q + CW'(1));
      push          = 1'b0;
      pop           = 1'b0;
      push_val      = nxt;

      // drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_type;
               key_in  = key_ext[KEY_BITS-1:0];
               lvl_in  = LW'(KEY_BITS - 1);
               node_in = '0;
               n_in    = '0;
               best_in = '0;
               pend_in = 1'b0;
               lnk_ra  = '0;
               st_in   = ST_OK;
               unique case (req_type)
                  OP_INS: begin
                     if (total_ff >= CW'(MAX_VALUES)) begin
                        st_in    = ST_FULL;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  OP_ERA: state_in = S_WALK;
                  OP_QRY: begin
                     if (total_ff == '0) begin
                        st_in    = ST_EMPTY;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_QLNK;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_WALK: begin
            // follow the key's bit, record the path
            if (nxt == '0) begin
               if (op_ff == OP_INS) begin
                  fail_in   = lvl_ff;
                  miss_in   = 1'b1;
                  plnk_in   = lnk_q;
                  parent_in = node_ff;
                  state_in  = S_CHK;
               end else begin
                  st_in    = ST_ABSENT;
                  state_in = S_DONE;
               end
            end else begin
               push    = 1'b1;
               n_in    = n_ff + NW'(1);
               node_in = nxt;
               lnk_ra  = nxt;
               cnt_ra  = nxt;
               if (lvl_ff == '0) begin
                  miss_in  = 1'b0;
                  fail_in  = '0;
                  state_in = S_CHK;
               end else begin
                  lvl_in = lvl_dn;
               end
            end
         end
         S_CHK: begin
            if (op_ff == OP_INS) begin
               if (need > (IW+1)'(NODE_COUNT - 1)) begin
                  st_in    = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  total_in = total_ff + CW'(1);
                  lvl_in   = fail_ff;
                  state_in = S_INC;
                  // hook the first new node under the parent
                  if (miss_ff) begin
                     lnk_wd = key_ff[fail_ff] ? {new_id, plnk_ff[IW-1:0]}
                                              : {plnk_ff[LKW-1:IW], new_id};
                     if (parent_ff == '0) begin
                        ctl.root_we = 1'b1;
                     end else begin
                        ctl.lnk_we = 1'b1;
                     end
                  end
               end
            end else begin
               if (cnt_q == '0) begin
                  st_in    = ST_ABSENT;
                  state_in = S_DONE;
               end else begin
                  total_in = total_ff - CW'(1);
                  state_in = S_INC;
               end
            end
         end
         S_INC: begin
            // read-modify-write the counts along the path, one node a cycle
            ctl.cnt_we = pend_ff;
            if (n_ff != '0) begin
               pop          = 1'b1;
               cnt_ra       = cell_val[0];
               pend_addr_in = cell_val[0];
               pend_in      = 1'b1;
               n_in         = n_ff - NW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (op_ff == OP_INS && miss_ff) begin
                     state_in = S_NEW;
                  end else begin
                     st_in    = ST_OK;
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_NEW: begin
            // take one node a cycle, linked to the next one
            nf_in      = new_id;
            lnk_wa     = new_id;
            cnt_wa     = new_id;
            cnt_wd     = CW'(1);
            ctl.lnk_we = 1'b1;
            ctl.cnt_we = 1'b1;
            if (lvl_ff == '0) begin
               lnk_wd   = '0;
               st_in    = ST_OK;
               state_in = S_DONE;
            end else begin
               lnk_wd = key_ff[lvl_dn] ? {child_id, IW'(0)} : {IW'(0), child_id};
               lvl_in = lvl_dn;
            end
         end
         S_QLNK: begin
            // look up the count behind the opposite bit
            other_in = kb ? lo : hi;
            same_in  = kb ? hi : lo;
            cnt_ra   = kb ? lo : hi;
            state_in = S_QCNT;
         end
         S_QCNT: begin
            node_in         = take ? other_ff : same_ff;
            lnk_ra          = take ? other_ff : same_ff;
            best_in[lvl_ff] = take;
            if (lvl_ff == '0) begin
               st_in    = ST_OK;
               state_in = S_DONE;
            end else begin
               lvl_in   = lvl_dn;
               state_in = S_QLNK;
            end
         end
         S_DONE: begin
            // hand the result to the response register
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_best_in   = best_ext[KEY_W-1:0];
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nf_ff        <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         nf_ff        <= nf_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         n_ff         <= n_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      lvl_ff        <= lvl_in;
      node_ff       <= node_in;
      best_ff       <= best_in;
      st_ff         <= st_in;
      fail_ff       <= fail_in;
      miss_ff       <= miss_in;
      plnk_ff       <= plnk_in;
      parent_ff     <= parent_in;
      other_ff      <= other_in;
      same_ff       <= same_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_xor = rsp_best_ff;
   assign rsp_status   = rsp_status_ff;

endmodule
`default_nettype wire

[bench/btx_checker.sv]
// Checker for the trie max-xor core: models the trie and compares every response.
`timescale 1ns / 1ps
module btx_checker
   import btx_pkg::*;
#(
   parameter int unsigned KEY_BITS   = 31,
   parameter int unsigned MAX_VALUES = 1024,
   parameter int unsigned NODE_COUNT = 32768
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [TYPE_W-1:0] req_type,
   input  wire logic [KEY_W-1:0]  req_key_value,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [KEY_W-1:0]  rsp_best_xor,
   input  wire logic [STAT_W-1:0] rsp_status,
   output int                     fail_count,
   output int                     pending
);

   typedef struct packed {
      logic [KEY_W-1:0]  best_xor;
      logic [STAT_W-1:0] status;
   } answer_type;

   // Shadow trie
   int unsigned link_lo [NODE_COUNT];
   int unsigned link_hi [NODE_COUNT];
   int unsigned node_cnt [NODE_COUNT];
   int unsigned free_top;
   int unsigned value_total;

   answer_type answers_due [$];

   function automatic int unsigned child_of(int unsigned node, logic b);
      if (node >= NODE_COUNT) return 0;
      return b ? link_hi[node] : link_lo[node];
   endfunction

   task automatic set_child(int unsigned node, logic b, int unsigned nxt);
      if (b) link_hi[node] = nxt;
      else link_lo[node] = nxt;
   endtask

   task automatic walk_insert(input logic [KEY_W-1:0] key, output logic [STAT_W-1:0] st);
      int unsigned node;
      int unsigned missing;
      int unsigned nxt;
      node = 0;
      missing = 0;
      st = ST_OK;
      if (value_total >= MAX_VALUES) begin
         st = ST_FULL;
         return;
      end
      for (int lv = KEY_BITS - 1; lv >= 0; lv--) begin
         nxt = child_of(node, key[lv]);
         if (nxt == 0) begin
            missing = lv + 1;
            break;
         end
         node = nxt;
      end
      if (longint'(free_top) + missing > longint'(NODE_COUNT - 1)) begin
         st = ST_FULL;
         return;
      end
      node = 0;
      node_cnt[0]++;
      for (int lv = KEY_BITS - 1; lv >= 0; lv--) begin
         nxt = child_of(node, key[lv]);
         if (nxt == 0) begin
            free_top++;
            nxt = free_top;
            link_lo[nxt] = 0;
            link_hi[nxt] = 0;
            node_cnt[nxt] = 0;
            set_child(node, key[lv], nxt);
         end
         node = nxt;
         node_cnt[node]++;
      end
      value_total++;
   endtask

   task automatic walk_erase(input logic [KEY_W-1:0] key, output logic [STAT_W-1:0] st);
      int unsigned node;
      int unsigned nxt;
      node = 0;
      st = ST_OK;
      for (int lv = KEY_BITS - 1; lv >= 0; lv--) begin
         nxt = child_of(node, key[lv]);
         if (nxt == 0) begin
            st = ST_ABSENT;
            return;
         end
         node = nxt;
      end
      if (node >= NODE_COUNT || node_cnt[node] == 0) begin
         st = ST_ABSENT;
         return;
      end
      node = 0;
      node_cnt[0]--;
      for (int lv = KEY_BITS - 1; lv >= 0; lv--) begin
         node = child_of(node, key[lv]);
         if (node == 0 || node >= NODE_COUNT) break;
         node_cnt[node]--;
      end
      value_total--;
   endtask

   function automatic logic [KEY_W-1:0] best_match(logic [KEY_W-1:0] key);
      int unsigned node;
      int unsigned other;
      logic [KEY_W-1:0] best;
      node = 0;
      best = '0;
      for (int lv = KEY_BITS - 1; lv >= 0; lv--) begin
         other = child_of(node, ~key[lv]);
         if (other != 0 && other < NODE_COUNT && node_cnt[other] > 0) begin
            best[lv] = 1'b1;
            node = other;
         end else begin
            node = child_of(node, key[lv]);
         end
      end
      return best;
   endfunction

   // Work out the response one request causes
   task automatic predict_answer(input logic [TYPE_W-1:0] op, input logic [KEY_W-1:0] key,
                                 output answer_type ans);
      logic [STAT_W-1:0] st;
      ans.best_xor = '0;
      ans.status = ST_OK;
      case (op)
         OP_INS: begin
            walk_insert(key, st);
            ans.status = st;
         end
         OP_ERA: begin
            walk_erase(key, st);
            ans.status = st;
         end
         OP_QRY: begin
            if (value_total == 0) ans.status = ST_EMPTY;
            else ans.best_xor = best_match(key);
         end
         default: ;
      endcase
   endtask

   // Compare responses first, then record the request taken at this edge
   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (reset) begin
         answers_due.delete();
         fail_count <= 0;
         pending <= 0;
         free_top = 0;
         value_total = 0;
         link_lo[0] = 0;
         link_hi[0] = 0;
         node_cnt[0] = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("unexpected response best_xor=%0h status=%0d", rsp_best_xor, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (rsp_best_xor !== want.best_xor) begin
                  $error("best_xor expected %0h actual %0h", want.best_xor, rsp_best_xor);
                  fail_count <= fail_count + 1;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_answer(req_type, req_key_value, got);
            answers_due.push_back(got);
         end
         pending <= answers_due.size();
      end
   end

endmodule

[bench/tb_top.sv]
// Testbench top: drives requests and response stalls, and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
   import btx_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [TYPE_W-1:0] req_type;
   logic [KEY_W-1:0]  req_key_value;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [KEY_W-1:0]  rsp_best_xor;
   logic [STAT_W-1:0] rsp_status;
   int                fail_count;
   int                pending;
   int                hold_cycles;
   int                idle_cycles;
   int                sent;
   logic [KEY_W-1:0]  kept_keys [$];

   binary_trie_max_xor_core uut (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_key_value,
      .rsp_valid, .rsp_stall, .rsp_best_xor, .rsp_status
   );

   btx_checker chk (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_key_value,
      .rsp_valid, .rsp_stall, .rsp_best_xor, .rsp_status, .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one request after a random gap and hold it until taken
   task automatic send_request(logic [TYPE_W-1:0] op, logic [KEY_W-1:0] key);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_key_value <= key;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
      if (sent == 60) hold_cycles = 400;
   endtask

   function automatic logic [KEY_W-1:0] any_key();
      return KEY_W'($urandom());
   endfunction

   // Receiver stall: random, with one long hold-off
   initial begin
      rsp_stall = 1'b0;
      hold_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if ($urandom_range(0, 99) < 25) begin
            rsp_stall <= 1'b1;
            if ($urandom_range(0, 49) == 0) hold_cycles = $urandom_range(10, 60);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any handshake
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      int r;
      logic [KEY_W-1:0] k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = OP_NOP;
      req_key_value = '0;
      sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty set, absent erase, unused type, extremes
      send_request(OP_QRY, '0);
      send_request(OP_ERA, '1);
      send_request(OP_NOP, 31'h5555_5555);
      send_request(OP_INS, '0);
      send_request(OP_QRY, '0);
      send_request(OP_QRY, '1);
      send_request(OP_INS, '1);
      send_request(OP_QRY, '0);
      send_request(OP_QRY, 31'h2AAA_AAAA);
      send_request(OP_INS, '0);
      send_request(OP_ERA, '0);
      send_request(OP_QRY, '1);
      send_request(OP_ERA, '0);
      send_request(OP_ERA, '0);
      send_request(OP_QRY, '1);
      send_request(OP_ERA, 31'h4000_0000);
      send_request(OP_ERA, '1);
      send_request(OP_QRY, 31'h1234_5678);
      send_request(OP_NOP, '1);

      // Random: fresh inserts, erases of kept or random keys, queries and unused types
      repeat (600) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            k = ($urandom_range(0, 9) == 0) ? 31'($urandom_range(0, 255)) : any_key();
            kept_keys.push_back(k);
            send_request(OP_INS, k);
         end else if (r < 72) begin
            if (kept_keys.size() > 0 && $urandom_range(0, 4) != 0) begin
               r = $urandom_range(0, kept_keys.size() - 1);
               k = kept_keys[r];
               kept_keys.delete(r);
            end else begin
               k = any_key();
            end
            send_request(OP_ERA, k);
         end else if (r < 95) begin
            send_request(OP_QRY, any_key());
         end else begin
            send_request(OP_NOP, any_key());
         end
      end

      // Insert copies of kept keys, mixed with queries and fresh keys
      repeat (330) begin
         r = $urandom_range(0, 99);
         if (r < 85 && kept_keys.size() > 0) begin
            send_request(OP_INS, kept_keys[$urandom_range(0, kept_keys.size() - 1)]);
         end else if (r < 95) begin
            send_request(OP_QRY, any_key());
         end else begin
            send_request(OP_INS, any_key());
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then let the block settle
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/btx_pkg.sv
hw/rtl/btx_path_cell.sv
hw/rtl/btx_node_mem.sv
hw/rtl/binary_trie_max_xor_core.sv
bench/btx_checker.sv
bench/tb_top.sv
